/* sv/macs_pkg.sv */
// ----------------------------------------------------------------------------
// macs_pkg
// Shared widths, codes and reset values of the moving-average crossover
// signal block.
// ----------------------------------------------------------------------------
package macs_pkg;

    // payload widths
    localparam int PRICE_W   = 24;
    localparam int KIND_W    = 2;
    localparam int BP_W      = 10;
    localparam int SIG_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int WIN_W     = 31;
    localparam int CFG_IDX_W = 2;

    // one in basis points, and a width that holds it plus a register value
    localparam int BP_ONE = 10000;
    localparam int BPC_W  = 14;

    // default window sizes
    localparam int SHORT_WINDOW_DEF = 5;
    localparam int LONG_WINDOW_DEF  = 20;
    localparam int MINUTE_DEPTH_DEF = 6;

    // word kinds
    localparam logic [KIND_W-1:0] KIND_DAILY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MINUTE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUOTE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // signal codes
    localparam logic [SIG_W-1:0] SIG_NONE = 2'd0;
    localparam logic [SIG_W-1:0] SIG_BUY  = 2'd1;
    localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_FEW_RAW   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW_VALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EVAL      = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND     = 2'd2;

    // register reset values
    localparam logic [BP_W-1:0] SPREAD_RST   = 10'd60;
    localparam logic [BP_W-1:0] MOMENTUM_RST = 10'd15;
    localparam logic [BP_W-1:0] BAND_RST     = 10'd30;

endpackage

/* sv/ma_crossover_momentum_signal_top.sv */
// ----------------------------------------------------------------------------
// ma_crossover_momentum_signal_top
// Short/long moving-average crossover with minute momentum confirmation.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry kind and price. Daily and minute closes shift into two
//   chains of history cells; clear zeroes the sample counts. A quote word is
//   evaluated and gives exactly one result word; other kinds give none.
//   Configuration registers are written through cfg_we / cfg_index / cfg_data;
//   the user must write them only while no quote is in flight; the block does not enforce it.
//   Throughput: one input word per cycle while in_stall is low. Running window
//   sums are kept alongside the daily chain, so a quote needs no sweep of the history.
//   Path: an accepted quote passes four compute stages, then four divider stages
//   for the window, then the output register that shows its result on out_valid.
//   Stall: results move into the output register; when that register is held
//   by out_stall and the next result is ready behind it, the whole pipeline
//   freezes and in_stall is raised. Otherwise input words keep flowing.
//   Reset: counts, running sums and history cells clear, registers take their
//   defaults, nothing is in flight.
// ----------------------------------------------------------------------------
module ma_crossover_momentum_signal_top
    import macs_pkg::*;
#(
    parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
    parameter int LONG_WINDOW  = LONG_WINDOW_DEF,
    parameter int MINUTE_DEPTH = MINUTE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BP_W-1:0]      cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KIND_W-1:0]    kind,
    input  logic [PRICE_W-1:0]   price,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SIG_W-1:0]     signal,
    output logic [STATUS_W-1:0]  status,
    output logic [WIN_W-1:0]     window_low,
    output logic [WIN_W-1:0]     window_high
);

    localparam int DAILY_DEPTH = LONG_WINDOW + 1;
    localparam int DCNT_W      = $clog2(DAILY_DEPTH + 1);
    localparam int MCNT_W      = $clog2(MINUTE_DEPTH + 1);
    localparam int SUM_W       = PRICE_W + $clog2(SHORT_WINDOW + LONG_WINDOW + 1);
    localparam int AW          = PRICE_W + $clog2(SHORT_WINDOW * LONG_WINDOW + 1);
    localparam int NW          = AW + BPC_W;
    localparam int MW          = PRICE_W + BPC_W;
    localparam int XW          = SUM_W + BPC_W;
    localparam int DIVISOR     = 100 * SHORT_WINDOW;
    localparam int SHORT_TAP   = LONG_WINDOW - SHORT_WINDOW;
    localparam int DIV_LAT     = 4;

    typedef struct packed {
        logic [SIG_W-1:0]    sig;
        logic [STATUS_W-1:0] st;
    } tag_t;

    // configuration
    logic [BP_W-1:0] spread_reg;
    logic [BP_W-1:0] momentum_reg;
    logic [BP_W-1:0] band_reg;

    // handshake and decode
    logic en;
    logic acc;
    logic push_daily;
    logic push_minute;
    logic quote_acc;
    logic clear_acc;
    logic daily_acc;

    // history chains and counts
    logic [PRICE_W-1:0] daily_q  [DAILY_DEPTH];
    logic [PRICE_W-1:0] daily_d  [DAILY_DEPTH];
    logic [PRICE_W-1:0] minute_q [MINUTE_DEPTH];
    logic [PRICE_W-1:0] minute_d [MINUTE_DEPTH];
    logic [DCNT_W-1:0]  raw_cnt_reg;
    logic [DCNT_W-1:0]  valid_cnt_reg;
    logic [MCNT_W-1:0]  minute_cnt_reg;
    logic [SUM_W-1:0]   sp_reg;
    logic [SUM_W-1:0]   lp_reg;

    // stage 1
    logic [STATUS_W-1:0] st0;
    logic [SUM_W-1:0]    s5_now;
    logic [SUM_W-1:0]    l_now;
    logic                v1_reg;
    logic [STATUS_W-1:0] st1_reg;
    logic [SUM_W-1:0]    s5_1_reg;
    logic [SUM_W-1:0]    l_1_reg;
    logic [SUM_W-1:0]    sp_1_reg;
    logic [SUM_W-1:0]    lp_1_reg;
    logic [PRICE_W-1:0]  m0_1_reg;
    logic [PRICE_W-1:0]  m1_1_reg;

    // stage 2
    logic                v2_reg;
    logic [STATUS_W-1:0] st2_reg;
    logic [SUM_W-1:0]    s5_2_reg;
    logic [AW-1:0]       a2_reg;
    logic [AW-1:0]       b2_reg;
    logic [AW-1:0]       pa2_reg;
    logic [AW-1:0]       pb2_reg;
    logic [MW-1:0]       mhi2_reg;
    logic [MW-1:0]       mup2_reg;
    logic [MW-1:0]       mdn2_reg;
    logic                m0z2_reg;

    // stage 3
    logic                v3_reg;
    logic [STATUS_W-1:0] st3_reg;
    logic [SUM_W-1:0]    s5_3_reg;
    logic                buyx3_reg;
    logic                sellx3_reg;
    logic                age3_reg;
    logic                ale3_reg;
    logic [NW-1:0]       na3_reg;
    logic [NW-1:0]       nup3_reg;
    logic [NW-1:0]       ndn3_reg;
    logic                momup3_reg;
    logic                momdn3_reg;
    logic                mom_zero;

    // stage 4
    logic                v4_reg;
    tag_t                tag4_reg;
    logic [XW-1:0]       xlo4_reg;
    logic [XW-1:0]       xhi4_reg;
    logic                buy3;
    logic                sell3;
    logic [SIG_W-1:0]    sig3;

    // divider alignment and output
    tag_t                tag_reg [DIV_LAT];
    logic [DIV_LAT-1:0]  tag_vld_reg;
    logic [WIN_W-1:0]    q_lo;
    logic [WIN_W-1:0]    q_hi;
    logic                out_valid_reg;
    logic [SIG_W-1:0]    signal_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [WIN_W-1:0]    window_low_reg;
    logic [WIN_W-1:0]    window_high_reg;
    logic                last_vld;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_reg   <= SPREAD_RST;
            momentum_reg <= MOMENTUM_RST;
            band_reg     <= BAND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SPREAD:   spread_reg   <= cfg_data;
                REG_MOMENTUM: momentum_reg <= cfg_data;
                REG_BAND:     band_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // pipeline freezes only when a result waits behind a held output word
    assign last_vld    = tag_vld_reg[DIV_LAT-1];
    assign en          = !(last_vld && out_valid_reg && out_stall);
    assign in_stall    = !en;
    assign acc         = in_valid && en;
    assign daily_acc   = acc && (kind == KIND_DAILY);
    assign push_daily  = daily_acc && (price != '0);
    assign push_minute = acc && (kind == KIND_MINUTE);
    assign quote_acc   = acc && (kind == KIND_QUOTE);
    assign clear_acc   = acc && (kind == KIND_CLEAR);

    // daily close chain, newest at the top
    for (genvar i = 0; i < DAILY_DEPTH; i++)
    begin : g_daily
        if (i == DAILY_DEPTH - 1)
        begin : g_head
            assign daily_d[i] = price;
        end
        else
        begin : g_link
            assign daily_d[i] = daily_q[i+1];
        end
        macs_cell #(.W(PRICE_W)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (push_daily),
            .din   (daily_d[i]),
            .dout  (daily_q[i])
        );
    end

    // minute close chain
    for (genvar i = 0; i < MINUTE_DEPTH; i++)
    begin : g_minute
        if (i == MINUTE_DEPTH - 1)
        begin : g_head
            assign minute_d[i] = price;
        end
        else
        begin : g_link
            assign minute_d[i] = minute_q[i+1];
        end
        macs_cell #(.W(PRICE_W)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (push_minute),
            .din   (minute_d[i]),
            .dout  (minute_q[i])
        );
    end

    // sample counts, saturating
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_cnt_reg    <= '0;
            valid_cnt_reg  <= '0;
            minute_cnt_reg <= '0;
        end
        else if (clear_acc)
        begin
            raw_cnt_reg    <= '0;
            valid_cnt_reg  <= '0;
            minute_cnt_reg <= '0;
        end
        else
        begin
            if (daily_acc && (raw_cnt_reg < DCNT_W'(DAILY_DEPTH)))
            begin
                raw_cnt_reg <= raw_cnt_reg + DCNT_W'(1);
            end
            if (push_daily && (valid_cnt_reg < DCNT_W'(DAILY_DEPTH)))
            begin
                valid_cnt_reg <= valid_cnt_reg + DCNT_W'(1);
            end
            if (push_minute && (minute_cnt_reg < MCNT_W'(MINUTE_DEPTH)))
            begin
                minute_cnt_reg <= minute_cnt_reg + MCNT_W'(1);
            end
        end
    end

    // running sums of the previous-bar windows over the stored closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
            lp_reg <= '0;
        end
        else if (push_daily)
        begin
            sp_reg <= sp_reg - SUM_W'(daily_q[SHORT_TAP]) + SUM_W'(daily_q[LONG_WINDOW]);
            lp_reg <= lp_reg - SUM_W'(daily_q[0]) + SUM_W'(daily_q[LONG_WINDOW]);
        end
    end

    // current-bar sums with the quote in place of the newest close
    assign s5_now = sp_reg - SUM_W'(daily_q[SHORT_TAP]) + SUM_W'(price);
    assign l_now  = lp_reg - SUM_W'(daily_q[0]) + SUM_W'(price);

    always_comb
    begin
        if ((raw_cnt_reg < DCNT_W'(DAILY_DEPTH)) || (minute_cnt_reg < MCNT_W'(MINUTE_DEPTH))
            || (price == '0))
        begin
            st0 = ST_FEW_RAW;
        end
        else if (valid_cnt_reg < DCNT_W'(DAILY_DEPTH))
        begin
            st0 = ST_FEW_VALID;
        end
        else
        begin
            st0 = ST_EVAL;
        end
    end

    // stage valids and divider tag line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            tag_vld_reg <= '0;
        end
        else if (en)
        begin
            v1_reg      <= quote_acc;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            tag_vld_reg <= {tag_vld_reg[DIV_LAT-2:0], v4_reg};
        end
    end

    // stage 1: snapshot at acceptance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg  <= st0;
            s5_1_reg <= s5_now;
            l_1_reg  <= l_now;
            sp_1_reg <= sp_reg;
            lp_1_reg <= lp_reg;
            m0_1_reg <= minute_q[0];
            m1_1_reg <= minute_q[MINUTE_DEPTH-1];
        end
    end

    // stage 2: cross-multiplied averages and momentum products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st2_reg  <= st1_reg;
            s5_2_reg <= s5_1_reg;
            a2_reg   <= AW'(s5_1_reg) * AW'(LONG_WINDOW);
            b2_reg   <= AW'(l_1_reg) * AW'(SHORT_WINDOW);
            pa2_reg  <= AW'(sp_1_reg) * AW'(LONG_WINDOW);
            pb2_reg  <= AW'(lp_1_reg) * AW'(SHORT_WINDOW);
            mhi2_reg <= MW'(m1_1_reg) * MW'(BP_ONE);
            mup2_reg <= MW'(m0_1_reg) * (MW'(BP_ONE) + MW'(momentum_reg));
            mdn2_reg <= MW'(m0_1_reg) * (MW'(BP_ONE) - MW'(momentum_reg));
            m0z2_reg <= (m0_1_reg == '0);
        end
    end

    // stage 3: crossover compares, momentum tests, band products
    assign mom_zero = (momentum_reg == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st3_reg    <= st2_reg;
            s5_3_reg   <= s5_2_reg;
            buyx3_reg  <= (pa2_reg <= pb2_reg) && (a2_reg > b2_reg);
            sellx3_reg <= (pa2_reg >= pb2_reg) && (a2_reg < b2_reg);
            age3_reg   <= (a2_reg >= b2_reg);
            ale3_reg   <= (a2_reg <= b2_reg);
            na3_reg    <= NW'(a2_reg) * NW'(BP_ONE);
            nup3_reg   <= NW'(b2_reg) * (NW'(BP_ONE) + NW'(spread_reg));
            ndn3_reg   <= NW'(b2_reg) * (NW'(BP_ONE) - NW'(spread_reg));
            momup3_reg <= m0z2_reg ? mom_zero : (mhi2_reg >= mup2_reg);
            momdn3_reg <= m0z2_reg ? mom_zero : (mhi2_reg <= mdn2_reg);
        end
    end

    // stage 4: decision, window numerators
    assign buy3  = buyx3_reg || (age3_reg && (na3_reg <= nup3_reg) && momup3_reg);
    assign sell3 = sellx3_reg || (ale3_reg && (na3_reg >= ndn3_reg) && momdn3_reg);

    always_comb
    begin
        if (st3_reg != ST_EVAL)
        begin
            sig3 = SIG_NONE;
        end
        else if (buy3)
        begin
            sig3 = SIG_BUY;
        end
        else if (sell3)
        begin
            sig3 = SIG_SELL;
        end
        else
        begin
            sig3 = SIG_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag4_reg.sig <= sig3;
            tag4_reg.st  <= st3_reg;
            xlo4_reg     <= XW'(s5_3_reg) * (XW'(BP_ONE) - XW'(band_reg));
            xhi4_reg     <= XW'(s5_3_reg) * (XW'(BP_ONE) + XW'(band_reg));
        end
    end

    // window dividers
    macs_div #(.XW(XW), .DIVISOR(DIVISOR)) u_div_lo (
        .clk (clk),
        .en  (en),
        .x   (xlo4_reg),
        .q   (q_lo)
    );

    macs_div #(.XW(XW), .DIVISOR(DIVISOR)) u_div_hi (
        .clk (clk),
        .en  (en),
        .x   (xhi4_reg),
        .q   (q_hi)
    );

    // decision tags travel beside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= tag4_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last_vld || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && last_vld)
        begin
            signal_reg      <= tag_reg[DIV_LAT-1].sig;
            status_reg      <= tag_reg[DIV_LAT-1].st;
            window_low_reg  <= (tag_reg[DIV_LAT-1].sig != SIG_NONE) ? q_lo : '0;
            window_high_reg <= (tag_reg[DIV_LAT-1].sig != SIG_NONE) ? q_hi : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign signal      = signal_reg;
    assign status      = status_reg;
    assign window_low  = window_low_reg;
    assign window_high = window_high_reg;

`ifndef SYNTHESIS
    // nonzero closes never outnumber all closes
    a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
        valid_cnt_reg <= raw_cnt_reg)
        else $error("valid daily count above raw daily count");

    // minute count saturates at the chain depth
    a_min_sat: assert property (@(posedge clk) disable iff (!rst_n)
        minute_cnt_reg <= MCNT_W'(MINUTE_DEPTH))
        else $error("minute count beyond depth");

    // no window without a signal
    a_win_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (signal_reg == SIG_NONE)) |->
        ((window_low_reg == '0) && (window_high_reg == '0)))
        else $error("window set with no signal");

    // signals come only from evaluated quotes
    a_sig_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_EVAL)) |-> (signal_reg == SIG_NONE))
        else $error("signal on a quote that was not evaluated");

    // window bounds in order
    a_win_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (signal_reg != SIG_NONE)) |-> (window_low_reg <= window_high_reg))
        else $error("window low above window high");
`endif

endmodule

/* sv/macs_cell.sv */
// ----------------------------------------------------------------------------
// macs_cell
// One history cell: holds a price and takes its neighbour's on a shift.
// ----------------------------------------------------------------------------
module macs_cell
    import macs_pkg::*;
#(
    parameter int W = PRICE_W
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         shift,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] value_reg;

    // stored close, cleared so that the running sums start consistent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (shift)
        begin
            value_reg <= din;
        end
    end

    assign dout = value_reg;

endmodule

/* sv/macs_div.sv */
// ----------------------------------------------------------------------------
// macs_div
// Pipelined floor division by a fixed divisor: reciprocal multiply split in
// two partial products, then a single correction step. Four stages.
// ----------------------------------------------------------------------------
module macs_div
    import macs_pkg::*;
#(
    parameter int XW      = 43,
    parameter int DIVISOR = 500
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [XW-1:0]    x,
    output logic [WIN_W-1:0] q
);

    localparam int DW    = $clog2(DIVISOR + 1);
    localparam int MW    = XW - $clog2(DIVISOR) + 1;
    localparam int LO_W  = XW / 2;
    localparam int HI_W  = XW - LO_W;
    localparam int PHI_W = HI_W + MW;
    localparam int PLO_W = LO_W + MW;
    localparam int PW    = XW + MW;
    localparam int QD_W  = MW + DW;
    localparam int RW    = (XW > QD_W) ? XW : QD_W;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << XW) / 64'(DIVISOR));

    logic [PHI_W-1:0] pp_hi_reg;
    logic [PLO_W-1:0] pp_lo_reg;
    logic [XW-1:0]    xa_reg;
    logic [MW-1:0]    q0_reg;
    logic [XW-1:0]    xb_reg;
    logic [QD_W-1:0]  qd_reg;
    logic [MW-1:0]    q0c_reg;
    logic [XW-1:0]    xc_reg;
    logic [WIN_W-1:0] q_reg;
    logic [PW-1:0]    prod_full;
    logic [RW-1:0]    rem;
    logic [MW-1:0]    q_fix;

    // partial products against the reciprocal
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_hi_reg <= PHI_W'(x[XW-1:LO_W]) * PHI_W'(RECIP);
            pp_lo_reg <= PLO_W'(x[LO_W-1:0]) * PLO_W'(RECIP);
            xa_reg    <= x;
        end
    end

    // quotient estimate, low by at most one
    assign prod_full = {pp_hi_reg, LO_W'(0)} + PW'(pp_lo_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg <= prod_full[PW-1:XW];
            xb_reg <= xa_reg;
        end
    end

    // estimate times divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qd_reg  <= QD_W'(q0_reg) * QD_W'(DIVISOR);
            q0c_reg <= q0_reg;
            xc_reg  <= xb_reg;
        end
    end

    // correction by the remainder
    assign rem   = RW'(xc_reg) - RW'(qd_reg);
    assign q_fix = (rem >= RW'(DIVISOR)) ? (q0c_reg + MW'(1)) : q0c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= WIN_W'(q_fix);
        end
    end

    assign q = q_reg;

endmodule

/* verif/ma_crossover_momentum_signal_top_tb.sv */
// ----------------------------------------------------------------------------
// ma_crossover_momentum_signal_top_tb
// Self-checking bench for the moving-average crossover signal block. A
// scoreboard mirrors the daily and minute history, predicts the result word
// of every accepted quote and checks result words in order. Stimulus is a
// short directed run, then random trading episodes under changing register
// settings, sender gaps, receiver stalls and one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ma_crossover_momentum_signal_top_tb;
    import macs_pkg::*;

    localparam int SHORT_N      = SHORT_WINDOW_DEF;
    localparam int LONG_N       = LONG_WINDOW_DEF;
    localparam int MINUTE_N     = MINUTE_DEPTH_DEF;
    localparam int DAILY_N      = LONG_N + 1;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TOTAL_WORDS  = 1150;
    localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

    typedef struct packed {
        logic [SIG_W-1:0]    sig;
        logic [STATUS_W-1:0] st;
        logic [WIN_W-1:0]    lo;
        logic [WIN_W-1:0]    hi;
    } quote_result_t;

    // history mirror, quote predictor and queue of expected result words
    class signal_scoreboard;
        logic [PRICE_W-1:0] daily_closes [DAILY_N];
        logic [PRICE_W-1:0] minute_closes [MINUTE_N];
        int raw_count;
        int valid_count;
        int minute_count;
        logic [BP_W-1:0] spread_bp;
        logic [BP_W-1:0] momentum_bp;
        logic [BP_W-1:0] band_bp;
        quote_result_t pending_quotes [$];
        int errors;
        int n_results;
        int n_eval;
        int n_buy;
        int n_sell;

        function new();
            foreach (daily_closes[i]) daily_closes[i] = '0;
            foreach (minute_closes[i]) minute_closes[i] = '0;
            raw_count    = 0;
            valid_count  = 0;
            minute_count = 0;
            spread_bp    = SPREAD_RST;
            momentum_bp  = MOMENTUM_RST;
            band_bp      = BAND_RST;
            errors       = 0;
            n_results    = 0;
            n_eval       = 0;
            n_buy        = 0;
            n_sell       = 0;
        endfunction

        function void set_regs(logic [BP_W-1:0] sp, logic [BP_W-1:0] mo, logic [BP_W-1:0] bd);
            spread_bp   = sp;
            momentum_bp = mo;
            band_bp     = bd;
        endfunction

        function int pending();
            return pending_quotes.size();
        endfunction

        // crossover and near-band decision for one quote
        function quote_result_t predict_quote(logic [PRICE_W-1:0] quote);
            logic [PRICE_W-1:0] bars [DAILY_N];
            logic [63:0] s_now, s_prev, l_now, l_prev;
            logic [63:0] a, b, pa, pb, m_first, m_last;
            logic mom_up, mom_down, buy_x, sell_x, near_buy, near_sell;
            quote_result_t r;
            r = '0;
            if (raw_count < DAILY_N || minute_count < MINUTE_N || quote == 0)
            begin
                r.st = ST_FEW_RAW;
                return r;
            end
            if (valid_count < DAILY_N)
            begin
                r.st = ST_FEW_VALID;
                return r;
            end
            r.st = ST_EVAL;
            bars = daily_closes;
            bars[DAILY_N-1] = quote;
            s_now  = '0;
            s_prev = '0;
            l_now  = '0;
            l_prev = '0;
            for (int i = 0; i < SHORT_N; i++)
            begin
                s_now  += bars[DAILY_N-SHORT_N+i];
                s_prev += bars[DAILY_N-1-SHORT_N+i];
            end
            for (int i = 0; i < LONG_N; i++)
            begin
                l_now  += bars[DAILY_N-LONG_N+i];
                l_prev += bars[DAILY_N-1-LONG_N+i];
            end
            a  = s_now * LONG_N;
            b  = l_now * SHORT_N;
            pa = s_prev * LONG_N;
            pb = l_prev * SHORT_N;

            // minute momentum, a zero base counts as no movement
            m_first = minute_closes[0];
            m_last  = minute_closes[MINUTE_N-1];
            if (m_first == 0)
            begin
                mom_up   = (momentum_bp == 0);
                mom_down = (momentum_bp == 0);
            end
            else
            begin
                mom_up   = m_last * BP_ONE >= m_first * (BP_ONE + momentum_bp);
                mom_down = m_last * BP_ONE <= m_first * (BP_ONE - momentum_bp);
            end

            buy_x     = (pa <= pb) && (a > b);
            sell_x    = (pa >= pb) && (a < b);
            near_buy  = (a >= b) && (a * BP_ONE <= b * (BP_ONE + spread_bp)) && mom_up;
            near_sell = (a <= b) && (a * BP_ONE >= b * (BP_ONE - spread_bp)) && mom_down;

            // buy wins over sell
            if (buy_x || near_buy)
                r.sig = SIG_BUY;
            else if (sell_x || near_sell)
                r.sig = SIG_SELL;

            if (r.sig != SIG_NONE)
            begin
                r.lo = WIN_W'((s_now * (BP_ONE - band_bp)) / (100 * SHORT_N));
                r.hi = WIN_W'((s_now * (BP_ONE + band_bp)) / (100 * SHORT_N));
            end
            return r;
        endfunction

        // accepted input word
        function void note_word(logic [KIND_W-1:0] k, logic [PRICE_W-1:0] p);
            case (k)
                KIND_DAILY:
                begin
                    if (raw_count < DAILY_N)
                        raw_count++;
                    if (p != 0)
                    begin
                        for (int i = 0; i < DAILY_N - 1; i++)
                            daily_closes[i] = daily_closes[i+1];
                        daily_closes[DAILY_N-1] = p;
                        if (valid_count < DAILY_N)
                            valid_count++;
                    end
                end
                KIND_MINUTE:
                begin
                    for (int i = 0; i < MINUTE_N - 1; i++)
                        minute_closes[i] = minute_closes[i+1];
                    minute_closes[MINUTE_N-1] = p;
                    if (minute_count < MINUTE_N)
                        minute_count++;
                end
                KIND_CLEAR:
                begin
                    raw_count    = 0;
                    valid_count  = 0;
                    minute_count = 0;
                end
                default:
                    pending_quotes.insert(pending_quotes.size(), predict_quote(p));
            endcase
        endfunction

        function void field_check(string name, longint want, longint got);
            if (want != got)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // accepted result word against the oldest expectation
        function void check_result(logic [SIG_W-1:0] sig, logic [STATUS_W-1:0] st,
                                   logic [WIN_W-1:0] lo, logic [WIN_W-1:0] hi);
            quote_result_t want;
            n_results++;
            if (st == ST_EVAL)
                n_eval++;
            if (sig == SIG_BUY)
                n_buy++;
            if (sig == SIG_SELL)
                n_sell++;
            if (pending_quotes.size() == 0)
            begin
                $display("%0t: unexpected result word: expected none, actual signal %0d status %0d",
                         $time, sig, st);
                errors++;
                return;
            end
            want = pending_quotes.pop_front();
            field_check("signal", want.sig, sig);
            field_check("status", want.st, st);
            field_check("window_low", want.lo, lo);
            field_check("window_high", want.hi, hi);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BP_W-1:0]      cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [KIND_W-1:0]    kind;
    logic [PRICE_W-1:0]   price;
    logic                 out_valid;
    logic                 out_stall;
    logic [SIG_W-1:0]     signal;
    logic [STATUS_W-1:0]  status;
    logic [WIN_W-1:0]     window_low;
    logic [WIN_W-1:0]     window_high;

    signal_scoreboard sb;
    int  words_sent;
    int  send_idle_pct;
    int  recv_stall_pct;
    logic hold_request;
    int  hold_left;
    int  cycle_count;

    ma_crossover_momentum_signal_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .price       (price),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .signal      (signal),
        .status      (status),
        .window_low  (window_low),
        .window_high (window_high)
    );

    // clock, 2 ns period
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // handshake monitors
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_word(kind, price);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(signal, status, window_low, window_high);
    end

    // receiver: random stalls, or a long hold when asked
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= rst_n && (int'($urandom_range(99)) < recv_stall_pct);
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
        $display("CHECKS FAILED");
        $finish;
    end

    // one input word, with random idle cycles ahead of it
    task automatic send_word(input logic [KIND_W-1:0] k, input logic [PRICE_W-1:0] p);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        price    <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // stop sending and let every expected result come out
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [BP_W-1:0] sp, input logic [BP_W-1:0] mo,
                              input logic [BP_W-1:0] bd);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SPREAD;
        cfg_data  <= sp;
        @(posedge clk);
        cfg_index <= REG_MOMENTUM;
        cfg_data  <= mo;
        @(posedge clk);
        cfg_index <= REG_BAND;
        cfg_data  <= bd;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_regs(sp, mo, bd);
    endtask

    task automatic start_phase(input int idle_pct, input int stall_pct,
                               input logic [BP_W-1:0] sp, input logic [BP_W-1:0] mo,
                               input logic [BP_W-1:0] bd);
        drain();
        write_regs(sp, mo, bd);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // price step in basis points with drift and jitter, kept positive
    function automatic logic [PRICE_W-1:0] walk(logic [PRICE_W-1:0] p, int drift_bp,
                                                int jitter_bp);
        longint v;
        int step;
        step = drift_bp + int'($urandom_range(2 * jitter_bp)) - jitter_bp;
        v = (longint'(p) * (10000 + step)) / 10000;
        if (v < 1)
            v = 1;
        if (v > longint'(PRICE_MAX))
            v = longint'(PRICE_MAX);
        return PRICE_W'(v);
    endfunction

    // edge cases ahead of the random run
    task automatic run_directed();
        send_word(KIND_QUOTE, '0);
        send_word(KIND_QUOTE, PRICE_MAX);
        send_word(KIND_CLEAR, PRICE_MAX);
        // zero close counts as raw but is not stored
        send_word(KIND_DAILY, '0);
        repeat (LONG_N) send_word(KIND_DAILY, PRICE_MAX);
        // zero minute base
        send_word(KIND_MINUTE, '0);
        repeat (MINUTE_N - 1) send_word(KIND_MINUTE, PRICE_MAX);
        // raw count full, one valid close short
        send_word(KIND_QUOTE, PRICE_MAX);
        send_word(KIND_DAILY, 24'd1);
        // flat history, no momentum
        send_word(KIND_QUOTE, PRICE_MAX);
        // quote collapse gives a sell crossover
        send_word(KIND_QUOTE, 24'd1);
        send_word(KIND_QUOTE, '0);
    endtask

    // one trading episode: history build-up, minute bars, quotes, some noise
    task automatic run_episode();
        logic [PRICE_W-1:0] level;
        logic [PRICE_W-1:0] mlevel;
        int drift;
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            level = PRICE_W'($urandom_range(100000, 1000));
        else if (roll < 90)
            level = PRICE_W'($urandom_range(PRICE_MAX, 1));
        else if (roll < 95)
            level = PRICE_W'($urandom_range(PRICE_MAX, 24'hFF0000));
        else
            level = PRICE_W'($urandom_range(60, 1));
        drift = int'($urandom_range(120)) - 60;
        if ($urandom_range(3) == 0)
            send_word(KIND_CLEAR, PRICE_W'($urandom));
        repeat ($urandom_range(26, 18))
        begin
            level = walk(level, drift, 100);
            send_word(KIND_DAILY, (int'($urandom_range(99)) < 4) ? '0 : level);
        end
        mlevel = level;
        repeat ($urandom_range(8, 4))
        begin
            mlevel = walk(mlevel, drift / 4, 30);
            send_word(KIND_MINUTE, (int'($urandom_range(99)) < 5) ? '0 : mlevel);
        end
        repeat ($urandom_range(6, 2))
        begin
            roll = $urandom_range(99);
            if (roll < 20)
            begin
                level = walk(level, drift, 100);
                send_word(KIND_DAILY, level);
            end
            else if (roll < 40)
            begin
                mlevel = walk(mlevel, drift / 4, 30);
                send_word(KIND_MINUTE, mlevel);
            end
            send_word(KIND_QUOTE, (int'($urandom_range(99)) < 3) ? '0 : walk(level, drift, 200));
        end
        // noise words
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(6, 1))
                send_word(KIND_W'($urandom), PRICE_W'($urandom));
    endtask

    // output held for a long stretch while quotes keep coming
    task automatic run_pressure();
        hold_request = 1'b1;
        repeat (60)
        begin
            if ($urandom_range(3) == 0)
                send_word(KIND_DAILY, PRICE_W'($urandom_range(PRICE_MAX, 1)));
            else
                send_word(KIND_QUOTE, PRICE_W'($urandom_range(PRICE_MAX, 1)));
        end
    endtask

    // main sequence
    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_SPREAD;
        cfg_data       = '0;
        in_valid       = 1'b0;
        kind           = KIND_DAILY;
        price          = '0;
        words_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, free flow
        run_directed();
        while (words_sent < 230)
            run_episode();

        // all registers at zero, sender gaps
        start_phase(46, 0, '0, '0, '0);
        while (words_sent < 460)
            run_episode();

        // all registers at full scale, receiver stalls
        start_phase(0, 46, {BP_W{1'b1}}, {BP_W{1'b1}}, {BP_W{1'b1}});
        while (words_sent < 690)
            run_episode();

        // random settings in range, both sides idle
        start_phase(13, 13, BP_W'($urandom_range(1000)), BP_W'($urandom_range(1000)),
                    BP_W'($urandom_range(1000)));
        while (words_sent < 920)
            run_episode();

        // long output hold, then free flow to the end
        start_phase(0, 0, 10'd1000, 10'd5, '0);
        run_pressure();
        while (words_sent < TOTAL_WORDS)
            run_episode();

        drain();
        $display("covered %0d input words and %0d quote results: %0d evaluated, %0d buy, %0d sell",
                 words_sent, sb.n_results, sb.n_eval, sb.n_buy, sb.n_sell);
        $display("register extremes, sender gaps, receiver stalls and a full-pipeline hold");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
